// ===== design/price_time_order_matcher_defines.svh =====
// Assertion macros used by the checker file of the order matcher.
`ifndef PRICE_TIME_ORDER_MATCHER_DEFINES_SVH
`define PRICE_TIME_ORDER_MATCHER_DEFINES_SVH

// Checked at every rising edge outside of reset.
`define PTOM_CHECK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Checked at every rising edge, reset included.
`define PTOM_CHECK_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ===== design/ptom_pkg.sv =====
package ptom_pkg;

  localparam logic [1:0] OP_LIMIT  = 2'd0;
  localparam logic [1:0] OP_MARKET = 2'd1;
  localparam logic [1:0] OP_CANCEL = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_DISABLED = 2'd2;

  localparam logic SIDE_BUY = 1'b0;

  localparam int TAG_SPACE = 1024;

  typedef struct packed {
    logic [1:0]  operation;
    logic        side;
    logic [3:0]  trader;
    logic [9:0]  order_tag;
    logic [15:0] order_qty;
    logic [15:0] order_price;
  } order_t;

  typedef struct packed {
    logic [47:0] traded_value;
    logic [47:0] maker_total;
    logic [47:0] taker_total;
    logic [1:0]  status;
  } result_t;

  typedef struct packed {
    logic [15:0] price;
    logic [31:0] seq;
    logic [3:0]  trader;
    logic [9:0]  tag;
    logic [15:0] qty;
  } entry_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] trader;
  } mark_t;

  typedef struct packed {
    logic load;
    logic mark_rec;
    logic top_rd;
    logic top_latch;
    logic remove_top;
    logic mark_clear;
    logic mul;
    logic acc;
    logic write_top;
    logic set_full;
    logic ins_start;
    logic ins_rd;
    logic ins_shift;
    logic ins_new;
    logic clear_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic is_read;
    logic is_cancel;
    logic enabled;
    logic match_empty;
    logic mark_valid;
    logic mark_match;
    logic price_stop;
    logic rq_zero;
    logic ins_needed;
    logic ins_full;
    logic ins_i_zero;
    logic ins_before;
    logic clear_last;
    logic out_free;
  } sts_t;

endpackage

// ===== design/ptom_ram.sv =====
module ptom_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/ptom_ctrl.sv =====
module ptom_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            order_valid,
  output logic            order_stall,
  input  ptom_pkg::sts_t  sts,
  output ptom_pkg::cmd_t  cmd
);

  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_DISP    = 4'd2;
  localparam logic [3:0] S_TOP_RD  = 4'd3;
  localparam logic [3:0] S_TOP_WT  = 4'd4;
  localparam logic [3:0] S_MARK_WT = 4'd5;
  localparam logic [3:0] S_ACC     = 4'd6;
  localparam logic [3:0] S_INS_CHK = 4'd7;
  localparam logic [3:0] S_INS_RD  = 4'd8;
  localparam logic [3:0] S_INS_WT  = 4'd9;
  localparam logic [3:0] S_DONE    = 4'd10;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign order_stall = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (order_valid) begin
          cmd.load = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        priority if (sts.is_read) begin
          state_next = S_DONE;
        end else if (sts.is_cancel) begin
          cmd.mark_rec = 1'b1;
          state_next = S_DONE;
        end else if (!sts.enabled) begin
          state_next = S_DONE;
        end else begin
          state_next = S_TOP_RD;
        end
      end
      S_TOP_RD: begin
        if (sts.match_empty) begin
          state_next = S_INS_CHK;
        end else begin
          cmd.top_rd = 1'b1;
          state_next = S_TOP_WT;
        end
      end
      S_TOP_WT: begin
        cmd.top_latch = 1'b1;
        state_next = S_MARK_WT;
      end
      S_MARK_WT: begin
        priority if (sts.mark_valid) begin
          // A cancel record at the top removes the entry or is dropped.
          if (sts.mark_match) cmd.remove_top = 1'b1;
          else cmd.mark_clear = 1'b1;
          state_next = S_TOP_RD;
        end else if (sts.price_stop) begin
          state_next = S_INS_CHK;
        end else begin
          cmd.mul = 1'b1;
          state_next = S_ACC;
        end
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (sts.rq_zero) begin
          cmd.remove_top = 1'b1;
          state_next = S_TOP_RD;
        end else begin
          cmd.write_top = 1'b1;
          state_next = S_DONE;
        end
      end
      S_INS_CHK: begin
        priority if (!sts.ins_needed) begin
          state_next = S_DONE;
        end else if (sts.ins_full) begin
          cmd.set_full = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.ins_start = 1'b1;
          state_next = S_INS_RD;
        end
      end
      S_INS_RD: begin
        if (sts.ins_i_zero) begin
          cmd.ins_new = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.ins_rd = 1'b1;
          state_next = S_INS_WT;
        end
      end
      S_INS_WT: begin
        if (sts.ins_before) begin
          cmd.ins_shift = 1'b1;
          state_next = S_INS_RD;
        end else begin
          cmd.ins_new = 1'b1;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== design/ptom_dp.sv =====
module ptom_dp #(
  parameter int BOOK_DEPTH = 64,
  parameter int TRADERS    = 16,
  parameter int ORDER_TAGS = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  ptom_pkg::order_t   order,
  input  logic               cfg_valid,
  input  logic [15:0]        cfg_data,
  input  logic               result_stall,
  output logic               result_valid,
  output ptom_pkg::result_t  result,
  input  ptom_pkg::cmd_t     cmd,
  output ptom_pkg::sts_t     sts
);

  localparam int BW = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
  localparam int CW = $clog2(BOOK_DEPTH + 1);
  localparam int TRW = $clog2(TRADERS);
  localparam int MARK_DEPTH = (ORDER_TAGS < ptom_pkg::TAG_SPACE) ? ORDER_TAGS
                                                                : ptom_pkg::TAG_SPACE;
  localparam int MW = $clog2(MARK_DEPTH);

  logic [15:0]            mask;
  logic [31:0]            seq;
  ptom_pkg::order_t       it;
  logic [47:0]            total;
  logic                   full_flg;
  ptom_pkg::entry_t       top;
  logic [31:0]            prod;
  logic [BW-1:0]          head [2];
  logic [CW-1:0]          count [2];
  logic [CW-1:0]          ins_i;
  logic                   ins_mode;
  logic [MW-1:0]          clr;
  logic [47:0]            maker [TRADERS];
  logic [47:0]            taker [TRADERS];

  logic                   cur_bk;
  logic [CW-1:0]          lidx;
  logic [BW:0]            psum;
  logic [BW-1:0]          paddr;
  logic [BW:0]            hsum;
  logic [BW-1:0]          head_inc;
  logic                   book_we;
  ptom_pkg::entry_t       book_wdata;
  ptom_pkg::entry_t       bq [2];
  ptom_pkg::entry_t       bq_cur;
  ptom_pkg::entry_t       new_entry;
  logic                   mark_we;
  logic [MW-1:0]          mark_waddr;
  ptom_pkg::mark_t        mark_wdata;
  ptom_pkg::mark_t        mark_q;
  logic [15:0]            fill;
  logic                   is_order;
  logic                   is_limit;
  logic                   trader_ok;
  logic                   mt_ok;
  logic                   tag_ok_in;
  logic                   tag_ok_top;
  logic [TRW-1:0]         tidx;
  logic [TRW-1:0]         midx;

  // Strict price-time rank of key a over key b in the book of side bk.
  function automatic logic ranks_before(input logic bk, input ptom_pkg::entry_t a,
                                        input ptom_pkg::entry_t b);
    logic r;
    if (a.price != b.price) begin
      r = (bk == ptom_pkg::SIDE_BUY) ? (a.price > b.price) : (a.price < b.price);
    end else begin
      r = (a.seq < b.seq);
    end
    return r;
  endfunction

  assign is_order   = (it.operation == ptom_pkg::OP_LIMIT) ||
                      (it.operation == ptom_pkg::OP_MARKET);
  assign is_limit   = (it.operation == ptom_pkg::OP_LIMIT);
  assign trader_ok  = (32'(it.trader) < 32'(TRADERS));
  assign mt_ok      = (32'(top.trader) < 32'(TRADERS));
  assign tag_ok_in  = (32'(it.order_tag) < 32'(ORDER_TAGS));
  assign tag_ok_top = (32'(top.tag) < 32'(ORDER_TAGS));
  assign tidx       = it.trader[TRW-1:0];
  assign midx       = top.trader[TRW-1:0];

  // Matching works on the opposite book, insertion on the order's own book.
  assign cur_bk = ins_mode ? it.side : ~it.side;

  always_comb begin
    priority if (cmd.ins_rd) begin
      lidx = ins_i - CW'(1);
    end else if (cmd.ins_shift || cmd.ins_new) begin
      lidx = ins_i;
    end else begin
      lidx = '0;
    end
  end

  // Each book is a ring: logical index 0 sits at the head pointer.
  always_comb begin
    psum = {1'b0, head[cur_bk]} + (BW + 1)'(lidx);
    if (psum >= (BW + 1)'(BOOK_DEPTH)) psum = psum - (BW + 1)'(BOOK_DEPTH);
    hsum = {1'b0, head[cur_bk]} + (BW + 1)'(1);
    if (hsum >= (BW + 1)'(BOOK_DEPTH)) hsum = hsum - (BW + 1)'(BOOK_DEPTH);
  end
  assign paddr    = psum[BW-1:0];
  assign head_inc = hsum[BW-1:0];

  assign new_entry = '{price: it.order_price, seq: seq, trader: it.trader,
                       tag: it.order_tag, qty: it.order_qty};

  assign bq_cur  = bq[cur_bk];
  assign book_we = cmd.write_top || cmd.ins_shift || cmd.ins_new;

  always_comb begin
    priority if (cmd.write_top) begin
      book_wdata = top;
    end else if (cmd.ins_shift) begin
      book_wdata = bq_cur;
    end else begin
      book_wdata = new_entry;
    end
  end

  for (genvar g = 0; g < 2; g++) begin : g_book
    ptom_ram #(
      .WIDTH($bits(ptom_pkg::entry_t)),
      .DEPTH(BOOK_DEPTH)
    ) u_book (
      .clk   (clk),
      .we    (book_we && (cur_bk == 1'(g))),
      .waddr (paddr),
      .wdata (book_wdata),
      .raddr (paddr),
      .rdata (bq[g])
    );
  end

  always_comb begin
    mark_we    = 1'b0;
    mark_waddr = top.tag[MW-1:0];
    mark_wdata = '0;
    priority if (cmd.clear_step) begin
      mark_we    = 1'b1;
      mark_waddr = clr;
    end else if (cmd.mark_rec) begin
      mark_we    = tag_ok_in;
      mark_waddr = it.order_tag[MW-1:0];
      mark_wdata = '{valid: 1'b1, trader: it.trader};
    end else if (cmd.mark_clear) begin
      mark_we    = 1'b1;
    end else begin
      mark_we    = 1'b0;
    end
  end

  ptom_ram #(
    .WIDTH($bits(ptom_pkg::mark_t)),
    .DEPTH(MARK_DEPTH)
  ) u_marks (
    .clk   (clk),
    .we    (mark_we),
    .waddr (mark_waddr),
    .wdata (mark_wdata),
    .raddr (bq_cur.tag[MW-1:0]),
    .rdata (mark_q)
  );

  assign fill = (it.order_qty < top.qty) ? it.order_qty : top.qty;

  always_ff @(posedge clk) begin
    if (rst) begin
      mask         <= '0;
      seq          <= '0;
      head         <= '{default: '0};
      count        <= '{default: '0};
      clr          <= '0;
      ins_mode     <= 1'b0;
      result_valid <= 1'b0;
      for (int t = 0; t < TRADERS; t++) begin
        maker[t] <= '0;
        taker[t] <= '0;
      end
    end else begin
      if (cfg_valid) mask <= cfg_data;
      if (cmd.clear_step) clr <= clr + MW'(1);
      if (cmd.load) ins_mode <= 1'b0;
      if (cmd.ins_start) ins_mode <= 1'b1;
      if (cmd.remove_top) begin
        head[cur_bk]  <= head_inc;
        count[cur_bk] <= count[cur_bk] - CW'(1);
      end
      if (cmd.ins_new) count[it.side] <= count[it.side] + CW'(1);
      if (cmd.acc) begin
        taker[tidx] <= taker[tidx] + {16'd0, prod};
        if (mt_ok) maker[midx] <= maker[midx] + {16'd0, prod};
      end
      if (cmd.finish) begin
        result_valid <= 1'b1;
        if ((it.operation == ptom_pkg::OP_CANCEL) || (is_order && sts.enabled)) begin
          seq <= seq + 32'd1;
        end
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      it       <= order;
      total    <= '0;
      full_flg <= 1'b0;
    end
    if (cmd.set_full) full_flg <= 1'b1;
    if (cmd.top_latch) top <= bq_cur;
    if (cmd.mul) begin
      prod         <= {16'd0, fill} * {16'd0, top.price};
      top.qty      <= top.qty - fill;
      it.order_qty <= it.order_qty - fill;
    end
    if (cmd.acc) total <= total + {16'd0, prod};
    if (cmd.ins_start) ins_i <= count[it.side];
    if (cmd.ins_shift) ins_i <= ins_i - CW'(1);
    if (cmd.finish) begin
      result.traded_value <= total;
      result.maker_total  <= (sts.is_read && trader_ok) ? maker[tidx] : '0;
      result.taker_total  <= (sts.is_read && trader_ok) ? taker[tidx] : '0;
      if (is_order && !sts.enabled) result.status <= ptom_pkg::ST_DISABLED;
      else if (full_flg) result.status <= ptom_pkg::ST_FULL;
      else result.status <= ptom_pkg::ST_DONE;
    end
  end

  assign sts.is_read     = (it.operation == ptom_pkg::OP_READ);
  assign sts.is_cancel   = (it.operation == ptom_pkg::OP_CANCEL);
  assign sts.enabled     = trader_ok && mask[it.trader];
  assign sts.match_empty = (count[cur_bk] == '0);
  assign sts.mark_valid  = mark_q.valid && tag_ok_top;
  assign sts.mark_match  = (mark_q.trader == top.trader);
  assign sts.price_stop  = is_limit && ((it.side == ptom_pkg::SIDE_BUY) ?
                           (top.price > it.order_price) : (top.price < it.order_price));
  assign sts.rq_zero     = (top.qty == '0);
  assign sts.ins_needed  = is_limit && (it.order_qty != '0);
  assign sts.ins_full    = (count[it.side] >= CW'(BOOK_DEPTH));
  assign sts.ins_i_zero  = (ins_i == '0);
  assign sts.ins_before  = ranks_before(it.side, new_entry, bq_cur);
  assign sts.clear_last  = (clr == MW'(MARK_DEPTH - 1));
  assign sts.out_free    = !result_valid || !result_stall;

endmodule

// ===== design/price_time_order_matcher.sv =====
// Price-time priority order matcher with a bid and an ask book of BOOK_DEPTH
// entries each. After reset the cancel store is swept clear, one tag per
// cycle, for min(ORDER_TAGS, 1024) tags while order_stall stays high; the
// enable register can be written at any time. Items are worked one at a time
// by a sequencer over single-port book memories with registered reads.
// A read, a cancel or an order from a disabled trader goes straight to its
// result. An order skips cancelled top entries, fills resting entries, stops
// when a top entry's price stops it and then checks for a remainder. An order
// that only partly fills a resting entry ends there. A resting remainder is
// compared with the entries of its book from the back until it finds its
// place, and may land at the front of its book. A stalled result holds the
// sequencer in its done state until it is taken.
module price_time_order_matcher #(
  parameter int BOOK_DEPTH = 64,
  parameter int TRADERS    = 16,
  parameter int ORDER_TAGS = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               order_valid,
  output logic               order_stall,
  input  ptom_pkg::order_t   order,
  output logic               result_valid,
  input  logic               result_stall,
  output ptom_pkg::result_t  result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data
);

  ptom_pkg::cmd_t cmd;
  ptom_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  ptom_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .order_valid (order_valid),
    .order_stall (order_stall),
    .sts         (sts),
    .cmd         (cmd)
  );

  ptom_dp #(
    .BOOK_DEPTH (BOOK_DEPTH),
    .TRADERS    (TRADERS),
    .ORDER_TAGS (ORDER_TAGS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .order        (order),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result       (result),
    .cmd          (cmd),
    .sts          (sts)
  );

endmodule

// ===== design/ptom_checker.sv =====
`include "price_time_order_matcher_defines.svh"

module ptom_checker (
  input logic               clk,
  input logic               rst,
  input logic               order_valid,
  input logic               order_stall,
  input ptom_pkg::order_t   order,
  input logic               result_valid,
  input logic               result_stall,
  input ptom_pkg::result_t  result,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input logic [15:0]        cfg_data
);

  `PTOM_CHECK_ALWAYS(a_reset_empty, rst |=> !result_valid, "result valid right after reset")

  `PTOM_CHECK(a_result_hold, result_valid && result_stall |=> result_valid && $stable(result), "stalled result changed")

  `PTOM_CHECK(a_one_at_a_time, order_valid && !order_stall |=> order_stall, "second order taken while busy")

  `PTOM_CHECK(a_disabled_zero, result_valid && result.status == ptom_pkg::ST_DISABLED |-> result.traded_value == 48'd0 && result.maker_total == 48'd0 && result.taker_total == 48'd0, "ignored order reported a value")

endmodule

bind price_time_order_matcher ptom_checker u_ptom_checker (.*);

// ===== tb/sv/price_time_order_matcher_test.sv =====
module price_time_order_matcher_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 64;
  localparam int NTRADERS = 16;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic order_valid = 1'b0;
  logic order_stall;
  ptom_pkg::order_t order = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  ptom_pkg::result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [15:0] cfg_data = '0;

  price_time_order_matcher dut (
    .clk(clk), .rst(rst),
    .order_valid(order_valid), .order_stall(order_stall), .order(order),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Book shadow: index 0 is the best entry of each side.
  ptom_pkg::entry_t bids[DEPTH];
  ptom_pkg::entry_t asks[DEPTH];
  int bid_n, ask_n;
  ptom_pkg::mark_t marks[ptom_pkg::TAG_SPACE];
  logic [47:0] maker_sum[NTRADERS];
  logic [47:0] taker_sum[NTRADERS];
  logic [31:0] seq_ctr;
  logic [15:0] enable_mask;

  ptom_pkg::result_t pending_results[$];
  int errors, mismatches, results_seen, items_sent, full_seen, fills_seen;
  int send_idle, recv_idle;
  bit hold_recv;

  function automatic bit ahead_of(bit s, ptom_pkg::entry_t a, ptom_pkg::entry_t b);
    if (a.price != b.price) begin
      return s == ptom_pkg::SIDE_BUY ? a.price > b.price : a.price < b.price;
    end
    return a.seq < b.seq;
  endfunction

  function automatic ptom_pkg::result_t match_order(ptom_pkg::order_t o);
    ptom_pkg::result_t r;
    bit s, limit, stop;
    logic [15:0] q, pr, fill, rq;
    logic [47:0] v;
    ptom_pkg::entry_t top, ne;
    int pos;
    r = '0;
    if (o.operation == ptom_pkg::OP_READ) begin
      r.maker_total = maker_sum[o.trader];
      r.taker_total = taker_sum[o.trader];
      return r;
    end
    if (o.operation == ptom_pkg::OP_CANCEL) begin
      marks[o.order_tag] = '{valid: 1'b1, trader: o.trader};
      seq_ctr++;
      return r;
    end
    if (!enable_mask[o.trader]) begin
      r.status = ptom_pkg::ST_DISABLED;
      return r;
    end
    s = o.side;
    limit = o.operation == ptom_pkg::OP_LIMIT;
    pr = limit ? o.order_price : 16'd0;
    q = o.order_qty;
    stop = 1'b0;
    while (!stop) begin
      if ((s == ptom_pkg::SIDE_BUY ? ask_n : bid_n) == 0) break;
      top = s == ptom_pkg::SIDE_BUY ? asks[0] : bids[0];
      if (marks[top.tag].valid) begin
        if (marks[top.tag].trader == top.trader) begin
          if (s == ptom_pkg::SIDE_BUY) begin
            for (int i = 0; i < ask_n - 1; i++) asks[i] = asks[i+1];
            ask_n--;
          end else begin
            for (int i = 0; i < bid_n - 1; i++) bids[i] = bids[i+1];
            bid_n--;
          end
        end else marks[top.tag] = '0;
        continue;
      end
      if (limit && (s == ptom_pkg::SIDE_BUY ? top.price > pr : top.price < pr)) break;
      rq = top.qty;
      fill = q < rq ? q : rq;
      q -= fill;
      rq -= fill;
      v = 48'(fill) * 48'(top.price);
      r.traded_value += v;
      maker_sum[top.trader] += v;
      taker_sum[o.trader] += v;
      fills_seen++;
      if (rq != 0) begin
        if (s == ptom_pkg::SIDE_BUY) asks[0].qty = rq; else bids[0].qty = rq;
        seq_ctr++;
        return r;
      end
      if (s == ptom_pkg::SIDE_BUY) begin
        for (int i = 0; i < ask_n - 1; i++) asks[i] = asks[i+1];
        ask_n--;
      end else begin
        for (int i = 0; i < bid_n - 1; i++) bids[i] = bids[i+1];
        bid_n--;
      end
    end
    if (limit && q != 0) begin
      ne = '{price: pr, seq: seq_ctr, trader: o.trader, tag: o.order_tag, qty: q};
      if ((s == ptom_pkg::SIDE_BUY ? bid_n : ask_n) >= DEPTH) begin
        r.status = ptom_pkg::ST_FULL;
        full_seen++;
      end else if (s == ptom_pkg::SIDE_BUY) begin
        pos = 0;
        while (pos < bid_n && !ahead_of(s, ne, bids[pos])) pos++;
        for (int i = bid_n; i > pos; i--) bids[i] = bids[i-1];
        bids[pos] = ne;
        bid_n++;
      end else begin
        pos = 0;
        while (pos < ask_n && !ahead_of(s, ne, asks[pos])) pos++;
        for (int i = ask_n; i > pos; i--) asks[i] = asks[i-1];
        asks[pos] = ne;
        ask_n++;
      end
    end
    seq_ctr++;
    return r;
  endfunction

  // Valid drops only while the sender idles; callers drop it after their last item.
  task automatic send_order(ptom_pkg::order_t o);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      order_valid <= 1'b0;
      @(posedge clk);
    end
    order_valid <= 1'b1;
    order <= o;
    @(posedge clk);
    while (order_stall) @(posedge clk);
    pending_results.push_back(match_order(o));
    items_sent++;
  endtask

  task automatic wait_drained();
    order_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_mask(logic [15:0] m);
    cfg_valid <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    enable_mask = m;
  endtask

  // Receiver side: stall decided on each edge, checked where stall was low.
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall) begin
        ptom_pkg::result_t want;
        results_seen++;
        if (pending_results.size() == 0) begin
          errors++;
          if (mismatches++ < 10) $display("Unexpected result %h", result);
        end else begin
          want = pending_results.pop_front();
          if (result.traded_value !== want.traded_value ||
              result.maker_total !== want.maker_total ||
              result.taker_total !== want.taker_total ||
              result.status !== want.status) begin
            errors++;
            if (mismatches++ < 10)
              $display({"Mismatch: expected value %h maker %h taker %h status %0d, ",
                        "got %h %h %h %0d"},
                       want.traded_value, want.maker_total, want.taker_total, want.status,
                       result.traded_value, result.maker_total, result.taker_total,
                       result.status);
          end
        end
      end
      result_stall <= hold_recv || (recv_idle > 0 && $urandom_range(99) < recv_idle);
    end
  end

  function automatic ptom_pkg::order_t rand_order(int tag_lo, int tag_hi);
    ptom_pkg::order_t o;
    int k;
    o.trader = 4'($urandom_range(NTRADERS - 1));
    o.order_tag = 10'($urandom_range(tag_hi, tag_lo));
    o.side = 1'($urandom_range(1));
    k = $urandom_range(99);
    o.operation = k < 55 ? ptom_pkg::OP_LIMIT : k < 72 ? ptom_pkg::OP_MARKET
                : k < 88 ? ptom_pkg::OP_CANCEL : ptom_pkg::OP_READ;
    k = $urandom_range(99);
    o.order_qty = k < 5 ? 16'd0 : k < 10 ? 16'hffff : k < 80 ? 16'($urandom_range(1, 60))
                 : 16'($urandom);
    k = $urandom_range(99);
    o.order_price = k < 4 ? 16'd0 : k < 8 ? 16'hffff
                   : k < 85 ? 16'($urandom_range(1000, 1015)) : 16'($urandom);
    return o;
  endfunction

  task automatic test_directed();
    // Disabled trader, reads of empty totals, and a cancel on no entry.
    send_order('{ptom_pkg::OP_LIMIT, 1'b0, 4'd3, 10'd1, 16'd10, 16'd100});
    send_order('{ptom_pkg::OP_READ, 1'b0, 4'd15, 10'd0, 16'd0, 16'd0});
    send_order('{ptom_pkg::OP_CANCEL, 1'b1, 4'd15, 10'h3ff, 16'hffff, 16'hffff});
    wait_drained();
    write_mask(16'hffff);
    send_order('{ptom_pkg::OP_LIMIT, 1'b1, 4'd0, 10'd5, 16'd10, 16'd100});
    send_order('{ptom_pkg::OP_LIMIT, 1'b1, 4'd1, 10'd6, 16'd20, 16'd100});
    send_order('{ptom_pkg::OP_LIMIT, 1'b1, 4'd2, 10'd7, 16'd5, 16'd90});
    send_order('{ptom_pkg::OP_LIMIT, 1'b0, 4'd3, 10'd8, 16'd0, 16'd200}); // zero qty
    send_order('{ptom_pkg::OP_LIMIT, 1'b0, 4'd3, 10'd9, 16'd20, 16'd100}); // partial stop
    send_order('{ptom_pkg::OP_CANCEL, 1'b0, 4'd1, 10'd6, 16'd0, 16'd0});
    send_order('{ptom_pkg::OP_CANCEL, 1'b0, 4'd9, 10'd5, 16'd0, 16'd0}); // wrong trader
    send_order('{ptom_pkg::OP_MARKET, 1'b0, 4'd4, 10'd10, 16'hffff, 16'hffff});
    send_order('{ptom_pkg::OP_LIMIT, 1'b0, 4'd5, 10'd11, 16'hffff, 16'hffff});
    send_order('{ptom_pkg::OP_MARKET, 1'b1, 4'd6, 10'd12, 16'hffff, 16'd0});
    send_order('{ptom_pkg::OP_LIMIT, 1'b1, 4'd7, 10'h3ff, 16'hffff, 16'd0});
    send_order('{ptom_pkg::OP_MARKET, 1'b0, 4'd15, 10'd0, 16'hffff, 16'd1});
    send_order('{ptom_pkg::OP_MARKET, 1'b1, 4'd8, 10'd0, 16'd1, 16'd0}); // empty book
    for (int t = 0; t < 16; t += 5) begin
      send_order('{ptom_pkg::OP_READ, 1'b0, 4'(t), 10'd0, 16'd0, 16'd0});
    end
    wait_drained();
  endtask

  task automatic test_book_full();
    ptom_pkg::order_t o;
    // Overfill the bid side with prices that cannot cross.
    for (int i = 0; i < DEPTH + 3; i++) begin
      o = '{ptom_pkg::OP_LIMIT, 1'b0, 4'(i % 16), 10'(200 + i), 16'd3, 16'(i % 7 + 1)};
      send_order(o);
    end
    send_order('{ptom_pkg::OP_MARKET, 1'b1, 4'd2, 10'd0, 16'd50, 16'd0});
    wait_drained();
  endtask

  task automatic test_backpressure();
    // Receiver holds off long enough that the input stalls.
    fork
      begin
        hold_recv = 1'b1;
        repeat (600) @(posedge clk);
        hold_recv = 1'b0;
      end
      begin
        for (int i = 0; i < 40; i++) send_order(rand_order(0, 63));
        order_valid <= 1'b0;
      end
    join
    wait_drained();
  endtask

  task automatic test_random(int n, logic [15:0] m);
    write_mask(m);
    for (int i = 0; i < n; i++) send_order(rand_order(0, $urandom_range(1) ? 63 : 1023));
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < ptom_pkg::TAG_SPACE; i++) marks[i] = '0;
    for (int i = 0; i < NTRADERS; i++) begin
      maker_sum[i] = '0;
      taker_sum[i] = '0;
    end
    bid_n = 0; ask_n = 0; seq_ctr = '0; enable_mask = '0;
    errors = 0; mismatches = 0; results_seen = 0; items_sent = 0;
    full_seen = 0; fills_seen = 0; hold_recv = 1'b0;
    send_idle = 0; recv_idle = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_book_full();
    send_idle = 26; recv_idle = 64;
    test_random(300, 16'h7fbd);
    test_backpressure();
    send_idle = 64; recv_idle = 26;
    test_random(250, 16'hffff);
    send_idle = 0; recv_idle = 0;
    test_random(250, 16'h0f0f);
    $display("Covered %0d orders, %0d results, %0d fills and %0d full-book drops.",
             items_sent, results_seen, fills_seen, full_seen);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #50ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
